>>> rtl/scan_code_line_editor_defines.svh
// assertion macros for the scan code line editor
// no dependencies; included by the modules that carry checks
`ifndef SCAN_CODE_LINE_EDITOR_DEFINES_SVH
`define SCAN_CODE_LINE_EDITOR_DEFINES_SVH

`ifndef ASSERT_OFF

`define SCLE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SCLE_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define SCLE_ASSERT(label, clk, rst_n, prop, msg)

`define SCLE_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

>>> rtl/scle_pkg.sv
// shared types, codes and the scan code to character table
// no dependencies
package scle_pkg;

  localparam int unsigned DEF_LINE_DEPTH = 256;
  localparam int unsigned DEF_ROW_BYTES  = 160;
  localparam int unsigned DEF_ROWS       = 24;

  localparam int unsigned CODE_W = 8;
  localparam int unsigned CAP_W  = 9;
  localparam int unsigned ADDR_W = 12;
  localparam int unsigned DATA_W = 8;

  localparam logic [CAP_W-1:0]  CAP_RESET     = 9'd256;
  localparam logic [6:0]        KEY_ENTER     = 7'h1c;
  localparam logic [6:0]        KEY_BACKSPACE = 7'h0e;
  localparam logic [DATA_W-1:0] ATTR_WHITE    = 8'h07;
  localparam logic [DATA_W-1:0] CHAR_BLANK    = 8'h20;
  localparam logic [DATA_W-1:0] LINE_TERM     = 8'h00;

  typedef enum logic [1:0] {
    KIND_SCREEN    = 2'd0,
    KIND_LINE_CHAR = 2'd1,
    KIND_LINE_END  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   data;
  } res_t;

  // up to three writes caused by one key, in emit order
  typedef struct packed {
    logic [1:0]   cnt;
    res_t [2:0]   ent;
  } plan_t;

  function automatic logic [DATA_W-1:0] key_char(input logic [6:0] code);
    logic [DATA_W-1:0] ch;
    case (code)
      7'h02: ch = 8'h31;
      7'h03: ch = 8'h32;
      7'h04: ch = 8'h33;
      7'h05: ch = 8'h34;
      7'h06: ch = 8'h35;
      7'h07: ch = 8'h36;
      7'h08: ch = 8'h37;
      7'h09: ch = 8'h38;
      7'h0a: ch = 8'h39;
      7'h0b: ch = 8'h30;
      7'h0c: ch = 8'h2d;
      7'h0d: ch = 8'h3d;
      7'h0e: ch = 8'h08;
      7'h0f: ch = 8'h09;
      7'h10: ch = 8'h71;
      7'h11: ch = 8'h77;
      7'h12: ch = 8'h65;
      7'h13: ch = 8'h72;
      7'h14: ch = 8'h74;
      7'h15: ch = 8'h79;
      7'h16: ch = 8'h75;
      7'h17: ch = 8'h69;
      7'h18: ch = 8'h6f;
      7'h19: ch = 8'h70;
      7'h1a: ch = 8'h5b;
      7'h1b: ch = 8'h5d;
      7'h1c: ch = 8'h0a;
      7'h1e: ch = 8'h61;
      7'h1f: ch = 8'h73;
      7'h20: ch = 8'h64;
      7'h21: ch = 8'h66;
      7'h22: ch = 8'h67;
      7'h23: ch = 8'h68;
      7'h24: ch = 8'h6a;
      7'h25: ch = 8'h6b;
      7'h26: ch = 8'h6c;
      7'h27: ch = 8'h3b;
      7'h28: ch = 8'h27;
      7'h29: ch = 8'h60;
      7'h2b: ch = 8'h5c;
      7'h2c: ch = 8'h7a;
      7'h2d: ch = 8'h78;
      7'h2e: ch = 8'h63;
      7'h2f: ch = 8'h76;
      7'h30: ch = 8'h62;
      7'h31: ch = 8'h6e;
      7'h32: ch = 8'h6d;
      7'h33: ch = 8'h2c;
      7'h34: ch = 8'h2e;
      7'h35: ch = 8'h2f;
      7'h39: ch = 8'h20;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

>>> rtl/scle_decode.sv
// key state, line length and screen cursor; turns one scan code into a write plan
// depends on scle_pkg and scan_code_line_editor_defines.svh
`include "scan_code_line_editor_defines.svh"

module scle_decode
  import scle_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = DEF_LINE_DEPTH,
  parameter int unsigned ROW_BYTES  = DEF_ROW_BYTES,
  parameter int unsigned ROWS       = DEF_ROWS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              commit_i,
  input  logic [CODE_W-1:0] code_i,
  input  logic [CAP_W-1:0]  cap_i,
  output plan_t             plan_o
);

  localparam int unsigned ScreenBytes = ROWS * ROW_BYTES;
  localparam int unsigned CurW = $clog2(ScreenBytes);
  localparam int unsigned ColW = $clog2(ROW_BYTES);
  localparam int unsigned LenW = $clog2(LINE_DEPTH);
  localparam int unsigned CmpW = ((LenW + 1) > CAP_W) ? (LenW + 1) : CAP_W;

  logic            await_q, await_d;
  logic [6:0]      held_q, held_d;
  logic [LenW-1:0] len_q, len_d;
  logic [CurW-1:0] cur_q, cur_d;
  logic [ColW-1:0] col_q, col_d;

  logic [CmpW-1:0] cap_x, cap_c;
  logic            room;
  logic [DATA_W-1:0] ch;
  logic [CurW-1:0] cur1, cur2;
  logic [ColW-1:0] col1, col2;
  logic [CurW:0]   row_next;
  logic [ColW:0]   col_back;

  function automatic logic [CurW-1:0] bump_cur(input logic [CurW-1:0] c);
    logic [CurW:0] n;
    n = (CurW+1)'(c) + (CurW+1)'(1);
    return (n == (CurW+1)'(ScreenBytes)) ? '0 : CurW'(n);
  endfunction

  function automatic logic [ColW-1:0] bump_col(input logic [ColW-1:0] c);
    logic [ColW:0] n;
    n = (ColW+1)'(c) + (ColW+1)'(1);
    return (n == (ColW+1)'(ROW_BYTES)) ? '0 : ColW'(n);
  endfunction

  // effective capacity, clamped to one..line depth
  always_comb begin
    cap_x = CmpW'(cap_i);
    if (cap_x == '0) begin
      cap_c = CmpW'(1);
    end else if (cap_x > CmpW'(LINE_DEPTH)) begin
      cap_c = CmpW'(LINE_DEPTH);
    end else begin
      cap_c = cap_x;
    end
    room = CmpW'(len_q) < (cap_c - CmpW'(1));
  end

  assign ch       = key_char(held_q);
  assign cur1     = bump_cur(cur_q);
  assign cur2     = bump_cur(cur1);
  assign col1     = bump_col(col_q);
  assign col2     = bump_col(col1);
  assign row_next = (CurW+1)'(cur_q) - (CurW+1)'(col_q) + (CurW+1)'(ROW_BYTES);
  // column two cells back, stepping into the row above when needed
  assign col_back = ((ColW+1)'(col_q) < (ColW+1)'(2))
                    ? (ColW+1)'(col_q) + (ColW+1)'(ROW_BYTES) - (ColW+1)'(2)
                    : (ColW+1)'(col_q) - (ColW+1)'(2);

  always_comb begin
    await_d = await_q;
    held_d  = held_q;
    len_d   = len_q;
    cur_d   = cur_q;
    col_d   = col_q;
    plan_o  = '0;
    for (int i = 0; i < 3; i++) begin
      plan_o.ent[i].kind = KIND_SCREEN;
    end

    if (!await_q) begin
      if (!code_i[CODE_W-1]) begin
        await_d = 1'b1;
        held_d  = code_i[6:0];
      end
    end else if (code_i[CODE_W-1]) begin
      await_d = 1'b0;
      if (held_q == KEY_ENTER) begin
        plan_o.cnt         = 2'd1;
        plan_o.ent[0].kind = KIND_LINE_END;
        plan_o.ent[0].addr = ADDR_W'(len_q);
        plan_o.ent[0].data = LINE_TERM;
        len_d = '0;
        col_d = '0;
        cur_d = (row_next >= (CurW+1)'(ScreenBytes)) ? '0 : CurW'(row_next);
      end else if (held_q == KEY_BACKSPACE) begin
        if (len_q != '0) begin
          len_d = len_q - LenW'(1);
          if ((CurW+1)'(cur_q) >= (CurW+1)'(2)) begin
            cur_d              = cur_q - CurW'(2);
            col_d              = ColW'(col_back);
            plan_o.cnt         = 2'd1;
            plan_o.ent[0].kind = KIND_SCREEN;
            plan_o.ent[0].addr = ADDR_W'(cur_q - CurW'(2));
            plan_o.ent[0].data = CHAR_BLANK;
          end
        end
      end else if (ch != '0 && room) begin
        plan_o.cnt         = 2'd3;
        plan_o.ent[0].kind = KIND_LINE_CHAR;
        plan_o.ent[0].addr = ADDR_W'(len_q);
        plan_o.ent[0].data = ch;
        plan_o.ent[1].kind = KIND_SCREEN;
        plan_o.ent[1].addr = ADDR_W'(cur_q);
        plan_o.ent[1].data = ch;
        plan_o.ent[2].kind = KIND_SCREEN;
        plan_o.ent[2].addr = ADDR_W'(cur1);
        plan_o.ent[2].data = ATTR_WHITE;
        len_d = len_q + LenW'(1);
        cur_d = cur2;
        col_d = col2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      await_q <= 1'b0;
      held_q  <= '0;
      len_q   <= '0;
      cur_q   <= '0;
      col_q   <= '0;
    end else if (commit_i) begin
      await_q <= await_d;
      held_q  <= held_d;
      len_q   <= len_d;
      cur_q   <= cur_d;
      col_q   <= col_d;
    end
  end

  `SCLE_ASSERT(a_release_clears_hold, clk_i, rst_ni, (commit_i && await_q && code_i[CODE_W-1]) |=> !await_q, "release beat did not clear held key")
  `SCLE_ASSERT_NEVER(a_col_in_row, clk_i, rst_ni, (ColW+1)'(col_q) >= (ColW+1)'(ROW_BYTES), "column ran past row end")

endmodule

>>> rtl/scle_res_queue.sv
// result register: holds one key's writes and hands them out one beat at a time
// depends on scle_pkg and scan_code_line_editor_defines.svh
`include "scan_code_line_editor_defines.svh"

module scle_res_queue
  import scle_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  load_i,
  input  plan_t plan_i,
  output logic  free_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output res_t  ent_o,
  output logic  last_o
);

  logic [1:0] cnt_q, cnt_d;
  logic [1:0] idx_q, idx_d;
  res_t [2:0] ent_q;
  logic       pop;

  assign out_valid_o = cnt_q != 2'd0;
  assign last_o      = cnt_q == 2'd1;
  assign ent_o       = ent_q[idx_q];
  assign pop         = out_valid_o && out_ready_i;
  // takes a new plan while the final beat of the old one leaves
  assign free_o      = (cnt_q == 2'd0) || (last_o && out_ready_i);

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (pop) begin
      cnt_d = cnt_q - 2'd1;
      idx_d = idx_q + 2'd1;
    end
    if (load_i) begin
      cnt_d = plan_i.cnt;
      idx_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= plan_i.ent;
    end
  end

  `SCLE_ASSERT_NEVER(a_idx_in_range, clk_i, rst_ni, (3'(idx_q) + 3'(cnt_q)) > 3'd3, "result index past plan end")
  `SCLE_ASSERT(a_mid_plan_stays, clk_i, rst_ni, (pop && !last_o) |=> out_valid_o, "plan dropped before final beat")
  `SCLE_ASSERT(a_plan_starts_first, clk_i, rst_ni, $rose(out_valid_o) |-> (idx_q == 2'd0), "new plan not shown from first write")

endmodule

>>> rtl/scan_code_line_editor.sv
// Scan code line editor: takes PS/2 set-1 bytes on the input channel and gives screen and
// line buffer writes on the output channel, one write per beat. A byte enters an input
// register, is decoded against the key state in one pass, and its writes (none, one or
// three) land together in a result register. A byte that causes at most one write is
// taken every cycle while the output channel is ready; a printable key makes three writes
// and holds the single output port until all three have left. The line capacity register
// is written through cfg_we_i.
// depends on scle_pkg, scle_decode and scle_res_queue

module scan_code_line_editor
  import scle_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = DEF_LINE_DEPTH,
  parameter int unsigned ROW_BYTES  = DEF_ROW_BYTES,
  parameter int unsigned ROWS       = DEF_ROWS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CAP_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CODE_W-1:0] scan_code_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        kind_o,
  output logic [ADDR_W-1:0] address_o,
  output logic [DATA_W-1:0] data_o,
  output logic              last_o
);

  logic [CAP_W-1:0]  cap_q;
  logic              in_vld_q;
  logic [CODE_W-1:0] code_q;
  logic              consume;
  logic              free;
  plan_t             plan;
  res_t              ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // beats with no writes never wait on the result register
  assign consume    = in_vld_q && ((plan.cnt == 2'd0) || free);
  assign in_ready_o = !in_vld_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      code_q <= scan_code_i;
    end
  end

  scle_decode #(
    .LINE_DEPTH (LINE_DEPTH),
    .ROW_BYTES  (ROW_BYTES),
    .ROWS       (ROWS)
  ) u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (consume),
    .code_i   (code_q),
    .cap_i    (cap_q),
    .plan_o   (plan)
  );

  scle_res_queue u_res_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (consume && (plan.cnt != 2'd0)),
    .plan_i      (plan),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ent_o       (ent),
    .last_o      (last_o)
  );

  assign kind_o    = ent.kind;
  assign address_o = ent.addr;
  assign data_o    = ent.data;

endmodule
